/* rtl/pcn_pkg.sv */
// shared types and constants for the palette chroma neutralizer
package pcn_pkg;

   // stream format constants
   localparam logic [7:0] MAGIC_FIRST  = 8'h50;
   localparam logic [7:0] MAGIC_SECOND = 8'h47;
   localparam logic [7:0] PALETTE_KIND = 8'h14;

   // header byte positions
   localparam logic [3:0] HDR_MAGIC_FIRST  = 4'd0;
   localparam logic [3:0] HDR_MAGIC_SECOND = 4'd1;
   localparam logic [3:0] HDR_KIND         = 4'd10;
   localparam logic [3:0] HDR_SIZE_HIGH    = 4'd11;
   localparam logic [3:0] HDR_SIZE_LOW     = 4'd12;

   // palette entry layout
   localparam logic [3:0] ENTRY_LEN    = 4'd5;
   localparam logic [2:0] ENTRY_CR_POS = 3'd2;
   localparam logic [2:0] ENTRY_CB_POS = 3'd3;

   // register reset values
   localparam logic       GRAYSCALE_RESET = 1'b1;
   localparam logic [7:0] NEUTRAL_RESET   = 8'd128;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_GRAYSCALE_ENABLE = 1'b0,
      CSR_NEUTRAL_CHROMA   = 1'b1
   } csr_index_type;

   // configuration seen by the parser
   typedef struct packed {
      logic       grayscale_enable;
      logic [7:0] neutral_chroma;
   } cfg_type;

   // one byte of the stream
   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } item_type;

   // one result
   typedef struct packed {
      logic [7:0] out_byte;
      logic       magic_error;
   } result_type;

endpackage

/* rtl/pgs_palette_chroma_neutralizer_unit.sv */
// top level: input stage, parser, result stage and configuration registers
//
// Passes a subtitle graphics segment stream through one byte per transaction,
// replacing the Cr and Cb bytes of complete palette entries by the neutral
// chroma value while grayscale is enabled, and flagging a bad header magic
// (sticky until the byte marked last). Throughput is one byte per clock when
// the result port does not stall. A byte taken moves from the input register
// into the result register and leaves from there. The rate is set by the parser
// state update, which handles one byte per cycle whenever the input stage
// advances. The configuration port is always ready; write it only while no
// byte is in flight.
module pgs_palette_chroma_neutralizer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_magic_error,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [0:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import pcn_pkg::*;

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   cfg_type    cfg_ff;
   result_type parser_result;
   logic       advance;
   logic       req_take;

   // advance the input stage into the result stage
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.in_byte   <= req_in_byte;
         in_item_ff.last_byte <= req_last_byte;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grayscale_enable <= GRAYSCALE_RESET;
         cfg_ff.neutral_chroma   <= NEUTRAL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_GRAYSCALE_ENABLE: cfg_ff.grayscale_enable <= csr_wdata[0];
            CSR_NEUTRAL_CHROMA:   cfg_ff.neutral_chroma   <= csr_wdata;
            default:              cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   pcn_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (parser_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= parser_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_ff.out_byte;
   assign rsp_magic_error = rsp_ff.magic_error;

`ifndef SYNTHESIS
   // a held byte is not dropped while the result stage is stalled
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_ready) |=> in_valid_ff)
      else $error("input stage lost a byte during a stall");

   // a byte seen with the error flag set is never rewritten
   a_error_passes: assert property (@(posedge clock) disable iff (reset)
      (advance && parser_result.magic_error) |-> parser_result.out_byte == in_item_ff.in_byte)
      else $error("byte rewritten while magic error is set");

   // with grayscale off every byte passes unchanged
   a_gray_off_passes: assert property (@(posedge clock) disable iff (reset)
      (advance && !cfg_ff.grayscale_enable) |-> parser_result.out_byte == in_item_ff.in_byte)
      else $error("byte rewritten with grayscale disabled");
`endif

endmodule

/* rtl/pcn_parser.sv */
// segment header and palette entry parser with chroma rewrite
module pcn_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  pcn_pkg::item_type   item,
   input  pcn_pkg::cfg_type    cfg,
   output pcn_pkg::result_type result
);
   import pcn_pkg::*;

   logic [3:0]  header_index_ff, header_index_in;
   logic        in_body_ff, in_body_in;
   logic [7:0]  segment_kind_ff, segment_kind_in;
   logic [15:0] body_remaining_ff, body_remaining_in;
   logic [2:0]  entry_offset_ff, entry_offset_in;
   logic        prefix_done_ff, prefix_done_in;
   logic        magic_mismatch_ff, magic_mismatch_in;

   logic [15:0] size_word;
   logic [15:0] remaining_dec;
   logic [15:0] need;
   logic [3:0]  offset_inc;
   logic [7:0]  out_byte;

   assign size_word     = {body_remaining_ff[15:8], item.in_byte};
   assign remaining_dec = body_remaining_ff - 16'd1;
   assign need          = {12'd0, ENTRY_LEN - {1'b0, entry_offset_ff}};
   assign offset_inc    = {1'b0, entry_offset_ff} + 4'd1;

   // next parser state and rewritten byte
   always_comb begin
      header_index_in   = header_index_ff;
      in_body_in        = in_body_ff;
      segment_kind_in   = segment_kind_ff;
      body_remaining_in = body_remaining_ff;
      entry_offset_in   = entry_offset_ff;
      prefix_done_in    = prefix_done_ff;
      magic_mismatch_in = magic_mismatch_ff;
      out_byte          = item.in_byte;

      if (!magic_mismatch_ff) begin
         if (in_body_ff) begin
            // body byte
            if (segment_kind_ff == PALETTE_KIND) begin
               if (!prefix_done_ff) begin
                  if (entry_offset_ff >= 3'd1) begin
                     prefix_done_in  = 1'b1;
                     entry_offset_in = 3'd0;
                  end else begin
                     entry_offset_in = 3'd1;
                  end
               end else begin
                  // rewrite cr/cb only when the whole entry fits in the body
                  if ((entry_offset_ff == ENTRY_CR_POS || entry_offset_ff == ENTRY_CB_POS) &&
                      body_remaining_ff >= need && cfg.grayscale_enable) begin
                     out_byte = cfg.neutral_chroma;
                  end
                  entry_offset_in = (offset_inc >= ENTRY_LEN) ? 3'd0 : offset_inc[2:0];
               end
            end
            body_remaining_in = remaining_dec;
            if (remaining_dec == 16'd0) begin
               in_body_in      = 1'b0;
               header_index_in = 4'd0;
               entry_offset_in = 3'd0;
               prefix_done_in  = 1'b0;
            end
         end else begin
            // header byte
            if (header_index_ff == HDR_MAGIC_FIRST && item.in_byte != MAGIC_FIRST) begin
               magic_mismatch_in = 1'b1;
            end
            if (header_index_ff == HDR_MAGIC_SECOND && item.in_byte != MAGIC_SECOND) begin
               magic_mismatch_in = 1'b1;
            end
            if (header_index_ff == HDR_KIND) begin
               segment_kind_in = item.in_byte;
            end
            if (header_index_ff == HDR_SIZE_HIGH) begin
               body_remaining_in = {item.in_byte, 8'd0};
            end
            if (header_index_ff == HDR_SIZE_LOW) begin
               body_remaining_in = size_word;
               header_index_in   = 4'd0;
               entry_offset_in   = 3'd0;
               prefix_done_in    = 1'b0;
               in_body_in        = (size_word != 16'd0);
            end else begin
               header_index_in = header_index_ff + 4'd1;
            end
         end
      end

      result.out_byte    = out_byte;
      result.magic_error = magic_mismatch_in;
   end

   // parser state, cleared after the final byte of a stream
   always_ff @(posedge clock) begin
      if (reset || (step && item.last_byte)) begin
         header_index_ff   <= 4'd0;
         in_body_ff        <= 1'b0;
         segment_kind_ff   <= 8'd0;
         body_remaining_ff <= 16'd0;
         entry_offset_ff   <= 3'd0;
         prefix_done_ff    <= 1'b0;
         magic_mismatch_ff <= 1'b0;
      end else if (step) begin
         header_index_ff   <= header_index_in;
         in_body_ff        <= in_body_in;
         segment_kind_ff   <= segment_kind_in;
         body_remaining_ff <= body_remaining_in;
         entry_offset_ff   <= entry_offset_in;
         prefix_done_ff    <= prefix_done_in;
         magic_mismatch_ff <= magic_mismatch_in;
      end
   end

endmodule

/* test/tb_pgs_palette_chroma_neutralizer_unit.sv */
// testbench for the palette chroma neutralizer: directed and random segment streams
`timescale 1ns / 100ps

module tb_pgs_palette_chroma_neutralizer_unit;
   import pcn_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 800;
   localparam int PHASES       = 5;
   localparam int LONG_HOLD    = 60;
   localparam int BURST_ITEMS  = 80;
   localparam int DRAIN_CYCLES = 4;
   localparam int IDLE_LIMIT   = 400;

   // one directed transaction, with an optional hand-written result
   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
      logic       typed;
      logic [7:0] out_byte;
      logic       magic_error;
   } directed_row_type;

   // palette segment of size 10: prefix, one full entry, then a partial entry
   // cut by the end of the stream; then a bad magic and a fresh start
   localparam directed_row_type DIRECTED_ROWS [26] = '{
      '{MAGIC_FIRST,  1'b0, 1'b1, MAGIC_FIRST,  1'b0},
      '{MAGIC_SECOND, 1'b0, 1'b1, MAGIC_SECOND, 1'b0},
      '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h5A, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hA5, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h12, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h34, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hC3, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h3C, 1'b0, 1'b0, 8'h00, 1'b0},
      '{PALETTE_KIND, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h0A, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h03, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hEB, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hF0, 1'b0, 1'b1, NEUTRAL_RESET, 1'b0},
      '{8'h10, 1'b0, 1'b1, NEUTRAL_RESET, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h02, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h7F, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hE0, 1'b1, 1'b1, 8'hE0, 1'b0},
      '{8'h00, 1'b0, 1'b1, 8'h00, 1'b1},
      '{MAGIC_SECOND, 1'b1, 1'b1, MAGIC_SECOND, 1'b1},
      '{MAGIC_FIRST,  1'b1, 1'b1, MAGIC_FIRST,  1'b0}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [7:0]       req_in_byte = 8'h00;
   logic             req_last_byte = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [7:0]       rsp_out_byte;
   logic             rsp_magic_error;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [0:0]       csr_index = CSR_GRAYSCALE_ENABLE;
   logic [7:0]       csr_wdata = 8'h00;

   // predictor state and register mirror
   logic             gray_enable_mirror;
   logic [7:0]       neutral_mirror;
   logic [3:0]       hdr_pos;
   logic             body_active;
   logic [7:0]       seg_kind;
   logic [15:0]      body_left;
   logic [2:0]       entry_pos;
   logic             prefix_seen;
   logic             magic_bad;

   result_type       expected_bytes[$];
   int               items_sent = 0;
   int               mismatches = 0;
   int               idle_cycles = 0;
   int               sender_left = 0;
   int               receiver_left = 0;
   bit               sender_quiet = 1'b0;
   bit               receiver_quiet = 1'b0;
   int               burst_left = 0;
   bit               hold_request = 1'b0;

   pgs_palette_chroma_neutralizer_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_magic_error (rsp_magic_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // parser back to the start of a header, error cleared
   function automatic void restart_parse();
      hdr_pos     = HDR_MAGIC_FIRST;
      body_active = 1'b0;
      seg_kind    = 8'h00;
      body_left   = 16'h0000;
      entry_pos   = 3'd0;
      prefix_seen = 1'b0;
      magic_bad   = 1'b0;
   endfunction

   // expected result of one byte, advancing the parser
   function automatic result_type neutralize_byte(input logic [7:0] b, input logic last);
      result_type r;
      r.out_byte = b;
      if (!magic_bad) begin
         if (body_active) begin
            if (seg_kind == PALETTE_KIND) begin
               if (!prefix_seen) begin
                  // palette id and version pass untouched
                  if (entry_pos >= 3'd1) begin
                     prefix_seen = 1'b1;
                     entry_pos   = 3'd0;
                  end else begin
                     entry_pos = 3'd1;
                  end
               end else begin
                  // chroma only rewritten when the whole entry fits in the body
                  if ((entry_pos == ENTRY_CR_POS || entry_pos == ENTRY_CB_POS) &&
                      body_left >= 16'(ENTRY_LEN) - 16'(entry_pos) && gray_enable_mirror)
                     r.out_byte = neutral_mirror;
                  entry_pos = (4'(entry_pos) + 4'd1 >= ENTRY_LEN) ? 3'd0 : entry_pos + 3'd1;
               end
            end
            body_left = body_left - 16'd1;
            if (body_left == 16'd0) begin
               body_active = 1'b0;
               hdr_pos     = HDR_MAGIC_FIRST;
               entry_pos   = 3'd0;
               prefix_seen = 1'b0;
            end
         end else begin
            // header bytes
            if (hdr_pos == HDR_MAGIC_FIRST && b != MAGIC_FIRST) magic_bad = 1'b1;
            if (hdr_pos == HDR_MAGIC_SECOND && b != MAGIC_SECOND) magic_bad = 1'b1;
            if (hdr_pos == HDR_KIND) seg_kind = b;
            if (hdr_pos == HDR_SIZE_HIGH) body_left = {b, 8'h00};
            if (hdr_pos == HDR_SIZE_LOW) begin
               body_left   = body_left | {8'h00, b};
               hdr_pos     = HDR_MAGIC_FIRST;
               entry_pos   = 3'd0;
               prefix_seen = 1'b0;
               body_active = (body_left != 16'd0);
            end else begin
               hdr_pos = hdr_pos + 4'd1;
            end
         end
      end
      r.magic_error = magic_bad;
      if (last) restart_parse();
      return r;
   endfunction

   // idle cycles for the next transaction, in stretches with and without gaps
   function automatic int draw_gap(inout int left, inout bit quiet);
      if (left == 0) begin
         left  = $urandom_range(10, 60);
         quiet = ($urandom_range(0, 3) == 0);
      end
      left--;
      return quiet ? 0 : $urandom_range(0, 17);
   endfunction

   // offer one byte and record its expected result when taken
   task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                            input result_type typed_result);
      int         gap;
      result_type predicted;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = draw_gap(sender_left, sender_quiet);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = neutralize_byte(b, last);
      expected_bytes.push_back(typed ? typed_result : predicted);
      items_sent++;
   endtask

   // stop offering and wait for every pending result
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write, only while idle
   task automatic write_reg(input csr_index_type idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_GRAYSCALE_ENABLE) gray_enable_mirror = data[0];
      else neutral_mirror = data;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one stream ending in a last byte: mostly segments, some noise
   task automatic send_stream();
      logic [7:0]  stream[$];
      int          segs;
      int          roll;
      int          body_len;
      logic [15:0] size;
      bit          cut_off;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         repeat ($urandom_range(1, 20)) stream.push_back(8'($urandom));
      end else begin
         segs    = $urandom_range(1, 4);
         cut_off = 1'b0;
         for (int s = 0; s < segs && !cut_off; s++) begin
            // size drawn first so the header can carry it
            roll = $urandom_range(0, 99);
            if (roll < 10) size = 16'd0;
            else if (roll < 20) size = 16'd1;
            else if (roll < 80) size = 16'($urandom_range(2, 40));
            else if (roll < 90) size = 16'($urandom_range(41, 300));
            else size = 16'($urandom);
            body_len = size;
            stream.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : MAGIC_FIRST);
            stream.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : MAGIC_SECOND);
            repeat (8) stream.push_back(8'($urandom));
            stream.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : PALETTE_KIND);
            stream.push_back(size[15:8]);
            stream.push_back(size[7:0]);
            // header cut short by the end of the stream
            if ($urandom_range(0, 19) == 0) begin
               repeat ($urandom_range(1, 12)) void'(stream.pop_back());
               cut_off = 1'b1;
               continue;
            end
            // huge bodies are always truncated
            if (roll >= 90) begin
               body_len = $urandom_range(0, 30);
               if (body_len > size) body_len = size;
               cut_off = 1'b1;
            end
            repeat (body_len) stream.push_back(8'($urandom));
         end
      end
      foreach (stream[i]) send_byte(stream[i], i == stream.size() - 1, 1'b0, '0);
   endtask

   // result side: random stalls, one long hold on request, field checks
   initial begin : result_side
      int         gap;
      result_type want;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            gap = LONG_HOLD;
         end else begin
            gap = draw_gap(receiver_left, receiver_quiet);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (expected_bytes.size() == 0) begin
            $error("unexpected transaction: out_byte %0h magic_error %0b",
                   rsp_out_byte, rsp_magic_error);
            mismatches++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %0h, actual %0h", want.out_byte, rsp_out_byte);
               mismatches++;
            end
            if (rsp_magic_error !== want.magic_error) begin
               $error("magic_error: expected %0b, actual %0b",
                      want.magic_error, rsp_magic_error);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus: directed rows, then random streams over several settings
   initial begin : stimulus
      int phase_start;
      bit pressed;
      pressed            = 1'b0;
      gray_enable_mirror = GRAYSCALE_RESET;
      neutral_mirror     = NEUTRAL_RESET;
      restart_parse();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part, with register reset values
      foreach (DIRECTED_ROWS[i])
         send_byte(DIRECTED_ROWS[i].in_byte, DIRECTED_ROWS[i].last_byte,
                   DIRECTED_ROWS[i].typed,
                   {DIRECTED_ROWS[i].out_byte, DIRECTED_ROWS[i].magic_error});
      settle();

      // random part, one register setting per phase
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_GRAYSCALE_ENABLE, 8'h00);
               write_reg(CSR_NEUTRAL_CHROMA, 8'h3C);
            end
            1: begin
               write_reg(CSR_GRAYSCALE_ENABLE, 8'h01);
               write_reg(CSR_NEUTRAL_CHROMA, 8'h00);
            end
            2: begin
               write_reg(CSR_NEUTRAL_CHROMA, 8'hFF);
               write_reg(CSR_GRAYSCALE_ENABLE, 8'h01);
            end
            3: begin
               write_reg(CSR_GRAYSCALE_ENABLE, 8'h00);
               write_reg(CSR_NEUTRAL_CHROMA, 8'hFF);
            end
            default: begin
               write_reg(CSR_GRAYSCALE_ENABLE, 8'h01);
               write_reg(CSR_NEUTRAL_CHROMA, 8'($urandom));
            end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < RANDOM_ITEMS / PHASES) begin
            // back-to-back bytes against a long result stall, then a full drain
            if (phase == 2 && !pressed && items_sent - phase_start > 60) begin
               pressed      = 1'b1;
               hold_request = 1'b1;
               burst_left   = BURST_ITEMS;
               // keep offering until the whole burst has gone out
               while (burst_left > 0) send_stream();
               settle();
            end else begin
               send_stream();
            end
         end
         settle();
      end

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
